>>> hw/rtl/pstg_pkg.sv
package pstg_pkg;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_BASE_RADIUS   = 2'd0,
        REG_PHASE_STEP    = 2'd1,
        REG_LISTEN_ENABLE = 2'd2
    } reg_index_t;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int COORD_W     = 16;
    localparam int LEVEL_W     = 14;
    localparam int RADIUS_W    = 14;
    localparam int STEP_W      = 16;
    localparam int TRIG_W      = 15;

    // quarter turn in Q30 radians
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // taylor series divisors (2n)(2n+1) for n = 1..8
    localparam logic [63:0] TAYLOR_DIV [8] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
    };

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } point_t;

    typedef struct packed {
        point_t erase_start;
        point_t erase_end;
        point_t draw_start;
        point_t draw_end;
    } result_t;

endpackage

>>> hw/rtl/polar_swirl_trail_generator_top.sv
// Swirl trail generator: each input transaction (center point and sound level) yields one
// result transaction with an erase segment (oldest trail point to the one after it) and a
// draw segment (newest trail point to a new point on a circle of radius base_radius plus
// level, the level only while listen_enable is set, around the center, at the current
// phase). The first transaction after reset fills every trail point but the newest with
// its center. The trail is a shift line of HISTORY_POINTS points, so oldest and newest
// sit at fixed taps. Sine and cosine come from a constant quarter-wave table of
// SINE_TABLE_DEPTH+1 entries with no interpolation; each takes one 16 by 16 bit
// multiply, and coordinates wrap to 16 bits. One transaction is taken every cycle while
// in_stall is low, and its result is registered; a skid register behind the result
// register takes one result under output stall, and in_stall rises only while it is full.
module polar_swirl_trail_generator_top #(
    parameter int HISTORY_POINTS   = 20,
    parameter int PHASE_BITS       = 16,
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_write,
    input  logic [pstg_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pstg_pkg::CFG_DATA_W-1:0]     cfg_data,
    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [pstg_pkg::COORD_W-1:0] center_x,
    input  logic signed [pstg_pkg::COORD_W-1:0] center_y,
    input  logic signed [pstg_pkg::LEVEL_W-1:0] sound_level,
    // output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [pstg_pkg::COORD_W-1:0] erase_start_x,
    output logic signed [pstg_pkg::COORD_W-1:0] erase_start_y,
    output logic signed [pstg_pkg::COORD_W-1:0] erase_end_x,
    output logic signed [pstg_pkg::COORD_W-1:0] erase_end_y,
    output logic signed [pstg_pkg::COORD_W-1:0] draw_start_x,
    output logic signed [pstg_pkg::COORD_W-1:0] draw_start_y,
    output logic signed [pstg_pkg::COORD_W-1:0] draw_end_x,
    output logic signed [pstg_pkg::COORD_W-1:0] draw_end_y
);

    import pstg_pkg::*;

    localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int FRAC_W  = PHASE_BITS - 2;
    localparam int PROD_W  = FRAC_W + IDX_W;
    localparam int WSTEP_W = STEP_W + PHASE_BITS;

    typedef logic [TRIG_W-1:0] sine_rom_t [SINE_TABLE_DEPTH+1];

    // quarter-wave sine table in Q15, built at elaboration
    function automatic sine_rom_t build_sine();
        sine_rom_t          rom;
        logic [63:0]        x;
        logic [63:0]        term;
        logic [63:0]        q;
        logic signed [63:0] sum;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++)
        begin
            x    = HALF_PI_Q30 * 64'(k) / SINE_TABLE_DEPTH;
            term = x;
            sum  = signed'(x);
            for (int n = 1; n <= 8; n++)
            begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / TAYLOR_DIV[n-1];
                if ((n & 1) != 0)
                    sum = sum - signed'(term);
                else
                    sum = sum + signed'(term);
            end
            if (sum < 0)
                sum = 64'sd0;
            q = (64'(sum) + 64'd16384) >> 15;
            if (q > 64'd32767)
                q = 64'd32767;
            rom[k] = TRIG_W'(q);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine();

    // table lookup with quadrant folding, result is signed Q15
    function automatic logic signed [COORD_W-1:0] sine_of(input logic [PHASE_BITS-1:0] p);
        logic [1:0]        quad;
        logic [PROD_W-1:0] prod;
        logic [IDX_W-1:0]  idx;
        logic [IDX_W-1:0]  ridx;
        logic [COORD_W-1:0] mag;
        quad = p[PHASE_BITS-1 -: 2];
        prod = PROD_W'(p[FRAC_W-1:0]) * PROD_W'(SINE_TABLE_DEPTH);
        idx  = IDX_W'(prod >> FRAC_W);
        ridx = IDX_W'(SINE_TABLE_DEPTH) - idx;
        case (quad)
            2'd0, 2'd2: mag = {1'b0, SINE_ROM[idx]};
            default:    mag = {1'b0, SINE_ROM[ridx]};
        endcase
        return quad[1] ? -signed'(mag) : signed'(mag);
    endfunction

    // offset r * trig truncated toward zero, plus center, wrapped to 16 bits
    function automatic logic signed [COORD_W-1:0] place(
        input logic signed [COORD_W-1:0] radius,
        input logic signed [COORD_W-1:0] trig,
        input logic signed [COORD_W-1:0] center
    );
        logic signed [2*COORD_W-1:0] prod;
        logic signed [2*COORD_W-1:0] biased;
        logic signed [2*COORD_W-1:0] offs;
        prod   = radius * trig;
        biased = prod + (prod < 0 ? (2*COORD_W)'(32767) : '0);
        offs   = biased >>> 15;
        return COORD_W'(offs + (2*COORD_W)'(center));
    endfunction

    // configuration registers
    logic [RADIUS_W-1:0]   base_radius_reg;
    logic [STEP_W-1:0]     phase_step_reg;
    logic                  listen_enable_reg;

    // block state
    point_t                trail_reg [HISTORY_POINTS];
    logic [PHASE_BITS-1:0] phase_reg;
    logic                  started_reg;

    // output and skid registers
    result_t               main_reg;
    logic                  main_valid_reg;
    result_t               skid_reg;
    logic                  skid_valid_reg;

    logic                  in_accept;
    logic                  out_fire;
    point_t                center;
    point_t                new_point;
    result_t               result_next;
    logic signed [COORD_W-1:0] radius;
    logic [WSTEP_W-1:0]    step_wide;
    logic [PHASE_BITS-1:0] step_scaled;

    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !skid_valid_reg;
    assign out_fire  = main_valid_reg && !out_stall;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_radius_reg   <= RADIUS_W'(64);
            phase_step_reg    <= STEP_W'(1024);
            listen_enable_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_BASE_RADIUS:   base_radius_reg   <= cfg_data[RADIUS_W-1:0];
                REG_PHASE_STEP:    phase_step_reg    <= cfg_data[STEP_W-1:0];
                REG_LISTEN_ENABLE: listen_enable_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // new swirl point
    always_comb
    begin
        center.x    = center_x;
        center.y    = center_y;
        radius      = signed'(COORD_W'(base_radius_reg))
                    + (listen_enable_reg ? COORD_W'(sound_level) : '0);
        new_point.x = place(radius,
                            sine_of(phase_reg + PHASE_BITS'(1 << (PHASE_BITS - 2))),
                            center_x);
        new_point.y = place(radius, sine_of(phase_reg), center_y);
        step_wide   = WSTEP_W'(phase_step_reg) << PHASE_BITS;
        step_scaled = PHASE_BITS'(step_wide >> STEP_W);
    end

    // segments, taking the center for every point but draw_end on the first transaction
    always_comb
    begin
        result_next.erase_start = started_reg ? trail_reg[HISTORY_POINTS-1] : center;
        result_next.erase_end   = started_reg ? trail_reg[HISTORY_POINTS-2] : center;
        result_next.draw_start  = started_reg ? trail_reg[0] : center;
        result_next.draw_end    = new_point;
    end

    // trail shift line, newest at tap zero
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            trail_reg[0] <= new_point;
            for (int j = 1; j < HISTORY_POINTS; j++)
                trail_reg[j] <= started_reg ? trail_reg[j-1] : center;
        end
    end

    // phase and first-transaction flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= '0;
            started_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            phase_reg   <= phase_reg + step_scaled;
            started_reg <= 1'b1;
        end
    end

    // result register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!main_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= in_accept;
            end
        end
        else if (in_accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!main_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
                main_reg <= skid_reg;
            else if (in_accept)
                main_reg <= result_next;
        end
        else if (in_accept)
        begin
            skid_reg <= result_next;
        end
    end

    // output ports
    assign out_valid     = main_valid_reg;
    assign erase_start_x = main_reg.erase_start.x;
    assign erase_start_y = main_reg.erase_start.y;
    assign erase_end_x   = main_reg.erase_end.x;
    assign erase_end_y   = main_reg.erase_end.y;
    assign draw_start_x  = main_reg.draw_start.x;
    assign draw_start_y  = main_reg.draw_start.y;
    assign draw_end_x    = main_reg.draw_end.x;
    assign draw_end_y    = main_reg.draw_end.y;

    // skid stage only fills behind a waiting result
    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid register full while result register empty");

    // a stalled result with a full skid keeps both transactions
    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && out_stall |=> skid_valid_reg && main_valid_reg)
        else $error("transaction lost under output stall");

    // first transaction, taken into an empty result register, starts its erase and draw segments at its own center
    a_first_fill: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && !started_reg && !main_valid_reg |=>
            out_valid && erase_start_x == $past(center_x) && draw_start_y == $past(center_y))
        else $error("first transaction did not fill trail with center");

    // any accepted transaction leaves the block started
    a_started: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> started_reg)
        else $error("started flag not set after transaction");

endmodule
